@@ sv/text_mode_console_writer_core_defines.svh @@
// assertion macros shared by the checker of the text console writer
// no dependencies; included by bare file name
`ifndef TEXT_MODE_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define TMCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define TMCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches reset itself
`define TMCW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tmcw_pkg.sv @@
// shared constants and types of the text console writer
// no dependencies; used by the screen ram and the core
package tmcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int OCOL_W  = 7;
  localparam int OROW_W  = 5;
  localparam int WORD_W  = 16;
  localparam int ATTR_W  = 8;

  // attribute and blank character
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // control characters
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHAR,
    S_SCRL_PRIME,
    S_SCRL,
    S_FILL,
    S_RDOUT
  } state_t;

endpackage

@@ sv/text_mode_console_writer_core.sv @@
// character-cell text console: cursor sequencer around one screen ram
// depends on tmcw_pkg and tmcw_ram
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------------
//  input    | in_operation, in_char_code, in_cell_index     | start high while busy low
//  result   | out_cursor_column/row, out_cell_word,         | out_valid, one cycle
//           | out_did_scroll                                |
//  config   | cfg_text_attribute                            | cfg_valid and cfg_ready
//
// put character and read cell each pass through a work state; an unused operation stays
//   in idle; the result is shown in the cycle the sequencer returns to idle.
// each scroll adds a row copy through the single ram port pair, after a priming read;
//   clear writes every cell once.
// after reset a clearing pass blanks the screen, busy high.
// results cannot be stalled; cfg_ready is always high.
module text_mode_console_writer_core #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          start,
  output logic                          busy,
  input  logic [tmcw_pkg::OP_W-1:0]     in_operation,
  input  logic [tmcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]    in_cell_index,
  // result items
  output logic                          out_valid,
  output logic [tmcw_pkg::OCOL_W-1:0]   out_cursor_column,
  output logic [tmcw_pkg::OROW_W-1:0]   out_cursor_row,
  output logic [tmcw_pkg::WORD_W-1:0]   out_cell_word,
  output logic                          out_did_scroll,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmcw_pkg::ATTR_W-1:0]   cfg_text_attribute
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int WW    = tmcw_pkg::WORD_W;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
  localparam logic [AW:0]   SRC_AHEAD  = (AW + 1)'(COLUMNS + 1);
  localparam logic [AW:0]   CELLS_EXT  = (AW + 1)'(CELLS);
  localparam logic [CW-1:0] COL_FULL   = CW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

  // registers
  tmcw_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [AW-1:0]    row_base_r, row_base_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [WW-1:0]    fill_word_r, fill_word_nxt;
  logic [tmcw_pkg::ATTR_W-1:0] attr_r, attr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             scroll_r, scroll_nxt;
  logic             ret_char_r, ret_char_nxt;
  logic [tmcw_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [WW-1:0]    word_r, word_nxt;
  logic             rd_inrng_r, rd_inrng_nxt;

  // ram ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WW-1:0]    ram_rdata;

  // shared helpers
  logic             accept;
  logic             nl_scroll;
  logic [RW-1:0]    nl_row;
  logic [AW-1:0]    nl_base;
  logic [CW:0]      tab_sum;
  logic [CW:0]      tab_col;
  logic [AW:0]      src_sum;
  logic [WW-1:0]    blank_word;

  tmcw_ram #(
    .WIDTH (WW),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = start && (state_r == tmcw_pkg::S_IDLE);
  assign blank_word = {attr_r, tmcw_pkg::BLANK_CHAR};

  // new line: step down a row, or stay on the last row and scroll
  assign nl_scroll = (row_r == LAST_ROW);
  assign nl_row    = nl_scroll ? row_r : row_r + RW'(1);
  assign nl_base   = nl_scroll ? row_base_r : row_base_r + ROW_STEP;

  // tab stop: next multiple of four, held at the full width
  assign tab_sum = {1'b0, col_r} + (CW + 1)'(4);
  assign tab_col = (({tab_sum[CW:2], 2'b00}) > {1'b0, COL_FULL}) ?
                   {1'b0, COL_FULL} : {tab_sum[CW:2], 2'b00};

  // source of the next row copy, one read ahead of the write
  assign src_sum = {1'b0, cnt_r} + SRC_AHEAD;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_base_nxt  = row_base_r;
    cnt_nxt       = cnt_r;
    fill_word_nxt = fill_word_r;
    attr_nxt      = attr_r;
    out_valid_nxt = 1'b0;
    scroll_nxt    = scroll_r;
    ret_char_nxt  = ret_char_r;
    ch_nxt        = ch_r;
    word_nxt      = word_r;
    rd_inrng_nxt  = rd_inrng_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = fill_word_r;
    ram_raddr     = '0;

    if (cfg_valid) begin
      attr_nxt = cfg_text_attribute;
    end

    case (state_r)
      tmcw_pkg::S_INIT, tmcw_pkg::S_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_CELL) begin
          cnt_nxt       = '0;
          state_nxt     = tmcw_pkg::S_IDLE;
          out_valid_nxt = (state_r == tmcw_pkg::S_FILL);
        end
      end

      tmcw_pkg::S_IDLE: begin
        ram_raddr = AW'(in_cell_index);
        if (accept) begin
          scroll_nxt = 1'b0;
          word_nxt   = '0;
          ch_nxt     = in_char_code;
          case (in_operation)
            tmcw_pkg::OP_PUT: begin
              state_nxt = tmcw_pkg::S_CHAR;
              // pending wrap is taken before the character
              if (col_r >= COL_FULL) begin
                col_nxt      = '0;
                row_nxt      = nl_row;
                row_base_nxt = nl_base;
                if (nl_scroll) begin
                  ret_char_nxt = 1'b1;
                  state_nxt    = tmcw_pkg::S_SCRL_PRIME;
                end
              end
            end
            tmcw_pkg::OP_CLEAR: begin
              fill_word_nxt = blank_word;
              cnt_nxt       = '0;
              col_nxt       = '0;
              row_nxt       = '0;
              row_base_nxt  = '0;
              state_nxt     = tmcw_pkg::S_FILL;
            end
            tmcw_pkg::OP_READ: begin
              rd_inrng_nxt = ({{(AW + 1 - tmcw_pkg::IDX_W > 0 ?
                               AW + 1 - tmcw_pkg::IDX_W : 0){1'b0}}, in_cell_index}
                              < {{(tmcw_pkg::IDX_W - AW - 1 > 0 ?
                               tmcw_pkg::IDX_W - AW - 1 : 0){1'b0}}, CELLS_EXT});
              state_nxt    = tmcw_pkg::S_RDOUT;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      tmcw_pkg::S_CHAR: begin
        state_nxt     = tmcw_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        case (ch_r)
          tmcw_pkg::CHAR_LF: begin
            col_nxt      = '0;
            row_nxt      = nl_row;
            row_base_nxt = nl_base;
            if (nl_scroll) begin
              ret_char_nxt  = 1'b0;
              out_valid_nxt = 1'b0;
              state_nxt     = tmcw_pkg::S_SCRL_PRIME;
            end
          end
          tmcw_pkg::CHAR_CR: begin
            col_nxt = '0;
          end
          tmcw_pkg::CHAR_TAB: begin
            col_nxt = tab_col[CW-1:0];
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = row_base_r + AW'(col_r);
            ram_wdata = {attr_r, ch_r};
            col_nxt   = col_r + CW'(1);
          end
        endcase
      end

      tmcw_pkg::S_SCRL_PRIME: begin
        // first source cell is the start of the second row
        ram_raddr  = ROW_STEP;
        cnt_nxt    = '0;
        scroll_nxt = 1'b1;
        state_nxt  = tmcw_pkg::S_SCRL;
      end

      tmcw_pkg::S_SCRL: begin
        // copy one cell up a row, blank the bottom row
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = (cnt_r < COPY_END) ? ram_rdata : blank_word;
        ram_raddr = (src_sum < CELLS_EXT) ? src_sum[AW-1:0] : '0;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == LAST_CELL) begin
          cnt_nxt = '0;
          if (ret_char_r) begin
            state_nxt = tmcw_pkg::S_CHAR;
          end else begin
            state_nxt     = tmcw_pkg::S_IDLE;
            out_valid_nxt = 1'b1;
          end
        end
      end

      tmcw_pkg::S_RDOUT: begin
        word_nxt      = rd_inrng_r ? ram_rdata : '0;
        state_nxt     = tmcw_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
      end

      default: begin
        state_nxt = tmcw_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmcw_pkg::S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      row_base_r  <= '0;
      cnt_r       <= '0;
      fill_word_r <= {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK_CHAR};
      attr_r      <= tmcw_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
      scroll_r    <= 1'b0;
      ret_char_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_base_r  <= row_base_nxt;
      cnt_r       <= cnt_nxt;
      fill_word_r <= fill_word_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
      scroll_r    <= scroll_nxt;
      ret_char_r  <= ret_char_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    word_r     <= word_nxt;
    rd_inrng_r <= rd_inrng_nxt;
  end

  // ports
  assign busy              = (state_r != tmcw_pkg::S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_cursor_column = tmcw_pkg::OCOL_W'(col_r);
  assign out_cursor_row    = tmcw_pkg::OROW_W'(row_r);
  assign out_cell_word     = word_r;
  assign out_did_scroll    = scroll_r;

endmodule

@@ sv/tmcw_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// depends on tmcw_pkg for default sizes
module tmcw_ram #(
  parameter int WIDTH = tmcw_pkg::WORD_W,
  parameter int DEPTH = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tmcw_checker.sv @@
// port-level checks of the text console writer, bound to the core
// depends on text_mode_console_writer_core_defines.svh
`include "text_mode_console_writer_core_defines.svh"

module tmcw_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted item is either in work or finished in the next cycle
  `TMCW_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid, "accepted item neither busy nor done")

  // a result only appears once the sequencer is back at idle
  `TMCW_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while busy")

  // reset starts the clearing pass and drops any result
  `TMCW_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, !rst_n, busy && !out_valid, "reset did not start the clearing pass")

  // a finished item leaves the block ready at once
  `TMCW_ASSERT_NEXT(a_result_ready, clk, rst_n, out_valid && !start, !busy, "block not ready after result")

endmodule

bind text_mode_console_writer_core tmcw_port_checker u_tmcw_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
